// ===== hdl/drr_pkg.sv =====
// Shared types and constants of the two-class deficit round robin scheduler.
package drr_pkg;

  // Deficit counter width and its saturation point
  localparam int unsigned DEF_W = 17;
  localparam logic [DEF_W-1:0] DEF_MAX = 17'd131071;

  // Fixed field widths
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned OLEN_W = 16;
  localparam int unsigned MAXB_W = 23;
  localparam int unsigned MAXP_W = 8;
  localparam int unsigned QNT_W  = 16;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Register reset values
  localparam logic [MAXP_W-1:0] RST_MAX_PACKETS = 8'd100;
  localparam logic [MAXB_W-1:0] RST_MAX_BYTES   = 23'd6553500;
  localparam logic [PORT_W-1:0] RST_PRIO_PORT   = 16'd3000;
  localparam logic [QNT_W-1:0]  RST_QUANTUM     = 16'd1;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Queue select codes
  localparam logic Q_LOW  = 1'b0;
  localparam logic Q_HIGH = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Register index codes (word address)
  typedef enum logic [2:0] {
    REG_LIMIT_MODE = 3'd0,
    REG_HIGH_MAXP  = 3'd1,
    REG_LOW_MAXP   = 3'd2,
    REG_HIGH_MAXB  = 3'd3,
    REG_LOW_MAXB   = 3'd4,
    REG_PRIO_PORT  = 3'd5,
    REG_QUANTUM    = 3'd6
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ENQ   = 6'b000010,
    S_CHK   = 6'b000100,
    S_VISIT = 6'b001000,
    S_POP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

// ===== hdl/drr_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module drr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/two_class_deficit_round_robin.sv =====
// Enqueue: the word passes S_ENQ, then S_DONE loads the result word; S_IDLE takes the next word.
// Dequeue: S_CHK, then S_VISIT once per queue visit (empty turns included) until a head fits,
//   at least once and data dependent; one shared saturating adder serves one visit per cycle;
//   then S_POP and S_DONE. Empty dequeue: S_CHK then S_DONE, same timing as an enqueue.
// A stalled result word holds the sequencer in S_DONE for as long as the stall lasts.
// Reset clears counts, bytes, deficits, turn (low first) and registers; FIFO RAMs are not cleared.
module two_class_deficit_round_robin #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned LEN_BITS    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [15:0]                 pkt_len_i,
  input  logic [drr_pkg::PORT_W-1:0]  dst_port_i,
  input  logic [drr_pkg::TAG_W-1:0]   pkt_tag_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        out_queue_o,
  output logic [drr_pkg::OLEN_W-1:0]  out_len_o,
  output logic [drr_pkg::TAG_W-1:0]   out_tag_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drr_pkg::APB_AW-1:0]  paddr,
  input  logic [drr_pkg::APB_DW-1:0]  pwdata,
  output logic [drr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BYTE_W = (LEN_BITS + CNT_W > drr_pkg::MAXB_W) ?
                                   (LEN_BITS + CNT_W) : drr_pkg::MAXB_W;
  localparam int unsigned CMP_W  = (CNT_W > drr_pkg::MAXP_W) ? CNT_W : drr_pkg::MAXP_W;
  localparam int unsigned DW     = LEN_BITS + drr_pkg::TAG_W;

  // configuration registers
  logic                       limit_mode_q;
  logic [drr_pkg::MAXP_W-1:0] hi_maxp_q, lo_maxp_q;
  logic [drr_pkg::MAXB_W-1:0] hi_maxb_q, lo_maxb_q;
  logic [drr_pkg::PORT_W-1:0] prio_port_q;
  logic [drr_pkg::QNT_W-1:0]  quantum_q;

  drr_pkg::reg_idx_e cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = drr_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_mode_q <= 1'b0;
      hi_maxp_q    <= drr_pkg::RST_MAX_PACKETS;
      lo_maxp_q    <= drr_pkg::RST_MAX_PACKETS;
      hi_maxb_q    <= drr_pkg::RST_MAX_BYTES;
      lo_maxb_q    <= drr_pkg::RST_MAX_BYTES;
      prio_port_q  <= drr_pkg::RST_PRIO_PORT;
      quantum_q    <= drr_pkg::RST_QUANTUM;
    end else if (cfg_wr) begin
      case (cfg_idx)
        drr_pkg::REG_LIMIT_MODE: limit_mode_q <= pwdata[0];
        drr_pkg::REG_HIGH_MAXP:  hi_maxp_q    <= pwdata[drr_pkg::MAXP_W-1:0];
        drr_pkg::REG_LOW_MAXP:   lo_maxp_q    <= pwdata[drr_pkg::MAXP_W-1:0];
        drr_pkg::REG_HIGH_MAXB:  hi_maxb_q    <= pwdata[drr_pkg::MAXB_W-1:0];
        drr_pkg::REG_LOW_MAXB:   lo_maxb_q    <= pwdata[drr_pkg::MAXB_W-1:0];
        drr_pkg::REG_PRIO_PORT:  prio_port_q  <= pwdata[drr_pkg::PORT_W-1:0];
        drr_pkg::REG_QUANTUM:    quantum_q    <= pwdata[drr_pkg::QNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (cfg_idx)
      drr_pkg::REG_LIMIT_MODE: prdata = drr_pkg::APB_DW'(limit_mode_q);
      drr_pkg::REG_HIGH_MAXP:  prdata = drr_pkg::APB_DW'(hi_maxp_q);
      drr_pkg::REG_LOW_MAXP:   prdata = drr_pkg::APB_DW'(lo_maxp_q);
      drr_pkg::REG_HIGH_MAXB:  prdata = drr_pkg::APB_DW'(hi_maxb_q);
      drr_pkg::REG_LOW_MAXB:   prdata = drr_pkg::APB_DW'(lo_maxb_q);
      drr_pkg::REG_PRIO_PORT:  prdata = drr_pkg::APB_DW'(prio_port_q);
      drr_pkg::REG_QUANTUM:    prdata = drr_pkg::APB_DW'(quantum_q);
      default:                 prdata = '0;
    endcase
  end

  // sequencer and queue state
  drr_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0]          head_q [2];
  logic [PTR_W-1:0]          tail_q [2];
  logic [CNT_W-1:0]          cnt_q  [2];
  logic [BYTE_W-1:0]         bytes_q[2];
  logic [drr_pkg::DEF_W-1:0] def_q  [2];
  logic                      turn_q;
  logic                      cur_q;

  // latched input word
  logic [LEN_BITS-1:0]        len_q;
  logic [drr_pkg::PORT_W-1:0] port_q;
  logic [drr_pkg::TAG_W-1:0]  tag_q;

  // staged result
  drr_pkg::status_e          res_status_q;
  logic                      res_queue_q;
  logic [LEN_BITS-1:0]       res_len_q;
  logic [drr_pkg::TAG_W-1:0] res_tag_q;

  // output register
  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic                       out_queue_q;
  logic [drr_pkg::OLEN_W-1:0] out_len_q;
  logic [drr_pkg::TAG_W-1:0]  out_tag_q;

  logic in_acc, out_free;
  assign in_stall_o = (state_q != drr_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // enqueue classification and limit check
  logic                enq_cls;
  logic                enq_drop;
  logic [BYTE_W:0]     enq_bsum;
  logic [CMP_W-1:0]    enq_cnt, enq_maxp;
  logic [drr_pkg::MAXB_W-1:0] enq_maxb;

  // FIFO RAMs, one per class
  logic [DW-1:0]       rd_data [2];
  logic                ram_we  [2];
  logic [LEN_BITS-1:0] head_len[2];
  logic [drr_pkg::TAG_W-1:0] head_tag[2];

  for (genvar gi = 0; gi < 2; gi++) begin : g_queue
    drr_ram #(
      .WIDTH(DW),
      .DEPTH(QUEUE_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[gi]),
      .waddr_i(tail_q[gi]),
      .wdata_i({len_q, tag_q}),
      .raddr_i(head_q[gi]),
      .rdata_o(rd_data[gi])
    );
    assign head_len[gi] = rd_data[gi][DW-1:drr_pkg::TAG_W];
    assign head_tag[gi] = rd_data[gi][drr_pkg::TAG_W-1:0];
    assign ram_we[gi]   = (state_q == drr_pkg::S_ENQ) && !enq_drop && (enq_cls == 1'(gi));
  end

  always_comb begin
    enq_cls  = (port_q == prio_port_q) ? drr_pkg::Q_HIGH : drr_pkg::Q_LOW;
    enq_maxp = CMP_W'(enq_cls ? hi_maxp_q : lo_maxp_q);
    enq_maxb = enq_cls ? hi_maxb_q : lo_maxb_q;
    enq_cnt  = CMP_W'(cnt_q[enq_cls]);
    enq_bsum = {1'b0, bytes_q[enq_cls]} + (BYTE_W+1)'(len_q);
    enq_drop = (cnt_q[enq_cls] >= CNT_W'(QUEUE_DEPTH));
    if (!limit_mode_q && (enq_cnt >= enq_maxp)) begin
      enq_drop = 1'b1;
    end
    if (limit_mode_q && (enq_bsum >= (BYTE_W+1)'(enq_maxb))) begin
      enq_drop = 1'b1;
    end
  end

  // shared deficit adder for one visit
  logic [drr_pkg::QNT_W-1:0]  q_eff;
  logic [drr_pkg::DEF_W:0]    dsum;
  logic [drr_pkg::DEF_W-1:0]  dsat;
  logic                       fits;

  always_comb begin
    q_eff = (quantum_q == '0) ? drr_pkg::QNT_W'(1) : quantum_q;
    dsum  = {1'b0, def_q[cur_q]} + (drr_pkg::DEF_W+1)'(q_eff);
    dsat  = (dsum > (drr_pkg::DEF_W+1)'(drr_pkg::DEF_MAX)) ? drr_pkg::DEF_MAX
                                                          : dsum[drr_pkg::DEF_W-1:0];
    fits  = (dsum >= (drr_pkg::DEF_W+1)'(head_len[cur_q]));
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      drr_pkg::S_IDLE:  if (in_acc) begin
        state_d = (cmd_i == drr_pkg::CMD_DEQ) ? drr_pkg::S_CHK : drr_pkg::S_ENQ;
      end
      drr_pkg::S_ENQ:   state_d = drr_pkg::S_DONE;
      drr_pkg::S_CHK:   begin
        state_d = (cnt_q[0] == '0 && cnt_q[1] == '0) ? drr_pkg::S_DONE : drr_pkg::S_VISIT;
      end
      drr_pkg::S_VISIT: if (cnt_q[cur_q] != '0 && fits) begin
        state_d = drr_pkg::S_POP;
      end
      drr_pkg::S_POP:   state_d = drr_pkg::S_DONE;
      drr_pkg::S_DONE:  if (out_free) begin
        state_d = drr_pkg::S_IDLE;
      end
      default:          state_d = drr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q  <= pkt_len_i[LEN_BITS-1:0];
      port_q <= dst_port_i;
      tag_q  <= pkt_tag_i;
    end
  end

  // Update queue state and stage results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        cnt_q[i]   <= '0;
        bytes_q[i] <= '0;
        def_q[i]   <= '0;
      end
      turn_q       <= 1'b0;
      cur_q        <= 1'b0;
      res_status_q <= drr_pkg::ST_EMPTY;
      res_queue_q  <= 1'b0;
      res_len_q    <= '0;
      res_tag_q    <= '0;
    end else begin
      case (state_q)
        drr_pkg::S_ENQ: begin
          res_queue_q <= enq_cls;
          res_len_q   <= '0;
          res_tag_q   <= '0;
          if (enq_drop) begin
            res_status_q <= drr_pkg::ST_DROPPED;
          end else begin
            res_status_q     <= drr_pkg::ST_ENQUEUED;
            cnt_q[enq_cls]   <= cnt_q[enq_cls] + CNT_W'(1);
            bytes_q[enq_cls] <= enq_bsum[BYTE_W-1:0];
            tail_q[enq_cls]  <= (tail_q[enq_cls] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : tail_q[enq_cls] + PTR_W'(1);
          end
        end
        drr_pkg::S_CHK: begin
          cur_q        <= turn_q;
          res_status_q <= drr_pkg::ST_EMPTY;
          res_queue_q  <= 1'b0;
          res_len_q    <= '0;
          res_tag_q    <= '0;
        end
        drr_pkg::S_VISIT: begin
          if (cnt_q[cur_q] != '0) begin
            def_q[cur_q] <= dsat;
          end
          if (!(cnt_q[cur_q] != '0 && fits)) begin
            cur_q <= !cur_q;
          end
        end
        drr_pkg::S_POP: begin
          res_status_q   <= drr_pkg::ST_DEQUEUED;
          res_queue_q    <= cur_q;
          res_len_q      <= head_len[cur_q];
          res_tag_q      <= head_tag[cur_q];
          bytes_q[cur_q] <= bytes_q[cur_q] - BYTE_W'(head_len[cur_q]);
          cnt_q[cur_q]   <= cnt_q[cur_q] - CNT_W'(1);
          head_q[cur_q]  <= (head_q[cur_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : head_q[cur_q] + PTR_W'(1);
          def_q[cur_q]   <= (cnt_q[cur_q] == CNT_W'(1)) ? '0
                            : def_q[cur_q] - drr_pkg::DEF_W'(head_len[cur_q]);
          turn_q         <= !cur_q;
        end
        default: ;
      endcase
    end
  end

  // Load and drain the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == drr_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == drr_pkg::S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_queue_q  <= res_queue_q;
      out_len_q    <= drr_pkg::OLEN_W'(res_len_q);
      out_tag_q    <= res_tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_queue_o = out_queue_q;
  assign out_len_o   = out_len_q;
  assign out_tag_o   = out_tag_q;

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_q[1] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_empty_no_def: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drr_pkg::S_IDLE) |-> ((cnt_q[0] != '0 || def_q[0] == '0) &&
                                      (cnt_q[1] != '0 || def_q[1] == '0)))
    else $error("empty queue holds deficit");

  a_pop_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drr_pkg::S_POP) |->
      (cnt_q[cur_q] != '0 && def_q[cur_q] >= drr_pkg::DEF_W'(head_len[cur_q])))
    else $error("popped head does not fit deficit");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drr_pkg::S_POP) |=> (state_q == drr_pkg::S_DONE))
    else $error("pop not followed by result");

endmodule

// ===== tb/two_class_deficit_round_robin_tb.sv =====
// Self-checking testbench for the two-class deficit round robin scheduler.
`timescale 1ns / 1ps

module two_class_deficit_round_robin_tb;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned DEF_LIMIT = 131071;

  typedef struct packed {
    logic        cmd;
    logic [15:0] len;
    logic [15:0] port;
    logic [15:0] tag;
  } sched_word_t;

  typedef struct packed {
    drr_pkg::status_e status;
    logic             queue;
    logic [15:0]      len;
    logic [15:0]      tag;
  } sched_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [15:0] pkt_len_i;
  logic [15:0] dst_port_i;
  logic [15:0] pkt_tag_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic        out_queue_o;
  logic [15:0] out_len_o;
  logic [15:0] out_tag_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [drr_pkg::APB_AW-1:0] paddr;
  logic [drr_pkg::APB_DW-1:0] pwdata;
  logic [drr_pkg::APB_DW-1:0] prdata;
  logic        pready;

  two_class_deficit_round_robin i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .pkt_len_i   (pkt_len_i),
    .dst_port_i  (dst_port_i),
    .pkt_tag_i   (pkt_tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_queue_o (out_queue_o),
    .out_len_o   (out_len_o),
    .out_tag_o   (out_tag_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow registers and scheduler state (index 0 low, 1 high)
  logic        mode_bytes;
  logic [7:0]  max_pkts [2];
  logic [22:0] max_bytes [2];
  logic [15:0] prio_port;
  logic [15:0] quantum;
  logic [15:0] ring_len [2][DEPTH];
  logic [15:0] ring_tag [2][DEPTH];
  int unsigned ring_head [2];
  int unsigned ring_count [2];
  longint unsigned queued_bytes [2];
  longint unsigned deficit [2];
  logic        turn_high;

  sched_word_t   pending_words[$];
  sched_result_t expected_results[$];
  int unsigned   n_errors;
  int unsigned   n_results;
  int unsigned   n_drops;
  int unsigned   n_dequeues;
  int unsigned   n_empty;
  bit            hold_off_req;
  bit            sender_pause;

  function automatic longint unsigned visits_for(int q, longint unsigned qn);
    longint unsigned hl;
    longint unsigned need;
    hl = ring_len[q][ring_head[q]];
    need = (hl > deficit[q]) ? hl - deficit[q] : 0;
    if (need == 0) begin
      return 1;
    end
    return (need + qn - 1) / qn;
  endfunction

  function automatic void grow_deficit(int q, longint unsigned k, longint unsigned qn);
    longint unsigned d;
    d = deficit[q] + k * qn;
    deficit[q] = (d > DEF_LIMIT) ? DEF_LIMIT : d;
  endfunction

  // Predict the result of one accepted word and update the shadow state
  function automatic sched_result_t schedule_word(sched_word_t w);
    sched_result_t r;
    int c;
    int t;
    int o;
    int win;
    bit drop;
    longint unsigned qn;
    longint unsigned kt;
    longint unsigned ko;
    int unsigned slot;
    r = '{status: drr_pkg::ST_ENQUEUED, queue: drr_pkg::Q_LOW, len: '0, tag: '0};
    if (w.cmd == drr_pkg::CMD_ENQ) begin
      c = (w.port == prio_port) ? 1 : 0;
      drop = ring_count[c] >= DEPTH;
      if (!mode_bytes && ring_count[c] >= max_pkts[c]) drop = 1;
      if (mode_bytes && queued_bytes[c] + w.len >= max_bytes[c]) drop = 1;
      r.queue = c[0];
      if (drop) begin
        r.status = drr_pkg::ST_DROPPED;
        return r;
      end
      slot = (ring_head[c] + ring_count[c]) % DEPTH;
      ring_len[c][slot] = w.len;
      ring_tag[c][slot] = w.tag;
      ring_count[c]++;
      queued_bytes[c] += w.len;
      return r;
    end
    if (ring_count[0] == 0 && ring_count[1] == 0) begin
      r.status = drr_pkg::ST_EMPTY;
      return r;
    end
    qn = (quantum == 0) ? 1 : quantum;
    t = turn_high;
    o = 1 - t;
    if (ring_count[t] != 0 && ring_count[o] != 0) begin
      kt = visits_for(t, qn);
      ko = visits_for(o, qn);
      if (kt <= ko) begin
        win = t;
        grow_deficit(t, kt, qn);
        grow_deficit(o, kt - 1, qn);
      end else begin
        win = o;
        grow_deficit(o, ko, qn);
        grow_deficit(t, ko, qn);
      end
    end else begin
      win = (ring_count[t] != 0) ? t : o;
      grow_deficit(win, visits_for(win, qn), qn);
    end
    slot = ring_head[win];
    r.status = drr_pkg::ST_DEQUEUED;
    r.queue = win[0];
    r.len = ring_len[win][slot];
    r.tag = ring_tag[win][slot];
    deficit[win] -= r.len;
    queued_bytes[win] -= r.len;
    ring_head[win] = (ring_head[win] + 1) % DEPTH;
    ring_count[win]--;
    if (ring_count[win] == 0) deficit[win] = 0;
    turn_high = (win == 0);
    return r;
  endfunction

  // Input stall as seen at the last rising edge
  logic in_stall_at_edge;

  // Driver: bursts of words with random gaps, pauses on request
  int unsigned burst_left;
  int unsigned gap_left;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_at_edge)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0 && !sender_pause) begin
          sched_word_t w;
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= w.cmd;
          pkt_len_i <= w.len;
          dst_port_i <= w.port;
          pkt_tag_i <= w.tag;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Capture input handshake and predict at the rising edge
  always @(posedge clk_i) begin
    sched_result_t pr;
    in_stall_at_edge <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pr = schedule_word('{cmd_i, pkt_len_i, dst_port_i, pkt_tag_i});
      expected_results.insert(expected_results.size(), pr);
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  int unsigned stall_phase;
  int unsigned hold_cnt;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_off_req && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result word: status %0d", status_o);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.status == drr_pkg::ST_DROPPED) n_drops++;
        if (e.status == drr_pkg::ST_DEQUEUED) n_dequeues++;
        if (e.status == drr_pkg::ST_EMPTY) n_empty++;
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          n_errors++;
        end
        if (out_queue_o !== e.queue) begin
          $error("out_queue: expected %0d, got %0d", e.queue, out_queue_o);
          n_errors++;
        end
        if (out_len_o !== e.len) begin
          $error("out_len: expected %0d, got %0d", e.len, out_len_o);
          n_errors++;
        end
        if (out_tag_o !== e.tag) begin
          $error("out_tag: expected %0d, got %0d", e.tag, out_tag_o);
          n_errors++;
        end
      end
    end
  end

  // Write one register through the configuration port, mirror it and read it back
  task automatic write_reg(drr_pkg::reg_idx_e idx, logic [31:0] value);
    logic [31:0] exp_val;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= drr_pkg::APB_AW'(4 * idx);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      drr_pkg::REG_LIMIT_MODE: begin
        mode_bytes = value[0];
        exp_val = {31'd0, value[0]};
      end
      drr_pkg::REG_HIGH_MAXP: begin
        max_pkts[1] = value[7:0];
        exp_val = {24'd0, value[7:0]};
      end
      drr_pkg::REG_LOW_MAXP: begin
        max_pkts[0] = value[7:0];
        exp_val = {24'd0, value[7:0]};
      end
      drr_pkg::REG_HIGH_MAXB: begin
        max_bytes[1] = value[22:0];
        exp_val = {9'd0, value[22:0]};
      end
      drr_pkg::REG_LOW_MAXB: begin
        max_bytes[0] = value[22:0];
        exp_val = {9'd0, value[22:0]};
      end
      drr_pkg::REG_PRIO_PORT: begin
        prio_port = value[15:0];
        exp_val = {16'd0, value[15:0]};
      end
      drr_pkg::REG_QUANTUM: begin
        quantum = value[15:0];
        exp_val = {16'd0, value[15:0]};
      end
      default: exp_val = '0;
    endcase
    #1;
    if (prdata !== exp_val) begin
      $error("prdata: expected %0d, got %0d", exp_val, prdata);
      n_errors++;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void add_word(logic cmd, logic [15:0] len, logic [15:0] port,
                                   logic [15:0] tag);
    sched_word_t w;
    w = '{cmd, len, port, tag};
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Random phase: mostly enqueue/dequeue mixes on the priority port and a few others
  task automatic random_phase(int unsigned n, int unsigned deq_pct);
    logic [15:0] port;
    logic [15:0] len;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: port = 16'($urandom);
        1: port = prio_port ^ 16'h0001;
        default: port = prio_port;
      endcase
      case ($urandom_range(0, 5))
        0: len = 16'($urandom);
        1: len = 16'hFFFF;
        2: len = 16'($urandom_range(0, 3));
        default: len = 16'($urandom_range(1, 1500));
      endcase
      add_word(($urandom_range(0, 99) < deq_pct) ? drr_pkg::CMD_DEQ : drr_pkg::CMD_ENQ,
               len, port, 16'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = 1'b0;
    pkt_len_i = '0;
    dst_port_i = '0;
    pkt_tag_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_stall_at_edge = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    hold_cnt = 0;
    hold_off_req = 0;
    sender_pause = 0;
    n_errors = 0;
    n_results = 0;
    n_drops = 0;
    n_dequeues = 0;
    n_empty = 0;
    mode_bytes = 1'b0;
    max_pkts[0] = drr_pkg::RST_MAX_PACKETS;
    max_pkts[1] = drr_pkg::RST_MAX_PACKETS;
    max_bytes[0] = drr_pkg::RST_MAX_BYTES;
    max_bytes[1] = drr_pkg::RST_MAX_BYTES;
    prio_port = drr_pkg::RST_PRIO_PORT;
    quantum = drr_pkg::RST_QUANTUM;
    for (int q = 0; q < 2; q++) begin
      ring_head[q] = 0;
      ring_count[q] = 0;
      queued_bytes[q] = 0;
      deficit[q] = 0;
    end
    turn_high = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty dequeue, extremes of fields, both classes, zero length
    add_word(drr_pkg::CMD_DEQ, 16'd0, 16'd0, 16'd0);
    add_word(drr_pkg::CMD_ENQ, 16'hFFFF, 16'd3000, 16'hFFFF);
    add_word(drr_pkg::CMD_ENQ, 16'd0, 16'hFFFF, 16'h0000);
    add_word(drr_pkg::CMD_ENQ, 16'd1, 16'd0, 16'hA5A5);
    add_word(drr_pkg::CMD_ENQ, 16'd64, 16'd3000, 16'h5A5A);
    for (int i = 0; i < 5; i++) add_word(drr_pkg::CMD_DEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Zero quantum, small packet limits, high port at maximum
    write_reg(drr_pkg::REG_QUANTUM, 32'd0);
    write_reg(drr_pkg::REG_HIGH_MAXP, 32'd2);
    write_reg(drr_pkg::REG_LOW_MAXP, 32'd0);
    write_reg(drr_pkg::REG_PRIO_PORT, 32'd65535);
    for (int i = 0; i < 4; i++) add_word(drr_pkg::CMD_ENQ, 16'(3 + i), 16'hFFFF, 16'(i));
    add_word(drr_pkg::CMD_ENQ, 16'd7, 16'd12, 16'd9);
    for (int i = 0; i < 4; i++) add_word(drr_pkg::CMD_DEQ, 16'd0, 16'd0, 16'd0);
    wait_drained();

    // Packet mode with limits at the physical capacity, then drain it
    write_reg(drr_pkg::REG_QUANTUM, 32'd65535);
    write_reg(drr_pkg::REG_HIGH_MAXP, 32'd128);
    write_reg(drr_pkg::REG_LOW_MAXP, 32'd128);
    write_reg(drr_pkg::REG_PRIO_PORT, 32'd0);
    random_phase(140, 0);
    random_phase(160, 90);
    wait_drained();

    // Byte mode with tight limits and a small quantum; long receiver hold-off
    write_reg(drr_pkg::REG_LIMIT_MODE, 32'd1);
    write_reg(drr_pkg::REG_HIGH_MAXB, 32'd5000);
    write_reg(drr_pkg::REG_LOW_MAXB, 32'd0);
    write_reg(drr_pkg::REG_QUANTUM, 32'd300);
    write_reg(drr_pkg::REG_PRIO_PORT, 32'd80);
    hold_off_req = 1;
    random_phase(200, 40);
    wait_drained();
    hold_off_req = 0;

    // Byte mode at the largest limits, quantum 1 leads to many visits on small words
    write_reg(drr_pkg::REG_HIGH_MAXB, 32'h7FFFFF);
    write_reg(drr_pkg::REG_LOW_MAXB, 32'h7FFFFF);
    write_reg(drr_pkg::REG_QUANTUM, 32'd1);
    for (int i = 0; i < 40; i++) begin
      add_word($urandom_range(0, 1) ? drr_pkg::CMD_DEQ : drr_pkg::CMD_ENQ,
               16'($urandom_range(0, 40)),
               $urandom_range(0, 1) ? 16'd80 : 16'd81, 16'($urandom));
    end
    wait_drained();

    // Packet mode with mid limits and a mid quantum
    write_reg(drr_pkg::REG_LIMIT_MODE, 32'd0);
    write_reg(drr_pkg::REG_HIGH_MAXP, 32'd20);
    write_reg(drr_pkg::REG_LOW_MAXP, 32'd40);
    write_reg(drr_pkg::REG_QUANTUM, 32'd1500);
    random_phase(300, 45);
    // Sender pauses until every expected result is back
    sender_pause = 1;
    while (in_valid_i || expected_results.size() > 0) @(posedge clk_i);
    sender_pause = 0;
    random_phase(300, 50);
    wait_drained();

    $display("Covered %0d results: %0d dequeues, %0d drops, %0d empty dequeues,",
             n_results, n_dequeues, n_drops, n_empty);
    $display("over packet and byte limits, zero and extreme quanta and a long output stall.");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/drr_pkg.sv
hdl/drr_ram.sv
hdl/two_class_deficit_round_robin.sv
tb/two_class_deficit_round_robin_tb.sv
